### rtl/core/ecrc_pkg.sv
// shared constants, types and helper functions of the euler channel rotation composer
`default_nettype none

package ecrc_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int EW               = FRAC_BITS + 2;
  localparam int NUM_ENT          = 9;
  localparam int ENT_IW           = $clog2(NUM_ENT);
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int ATAN_IW          = 5;
  localparam int ZW               = 34;
  localparam int CORDIC_FRAC      = 30;

  localparam int MW = 20;
  localparam int PW = 2 * MW;

  localparam int KIND_W      = 3;
  localparam int ANGLE_W     = 24;
  localparam int IN_TDATA_W  = ((ANGLE_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = KIND_W + 1;
  localparam int OUT_TDATA_W = ((NUM_ENT * EW + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_ROT_X = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROT_Y = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ROT_Z = 3'd5;

  localparam int FULL_TURN_Q8    = 92160;
  localparam int HALF_TURN_Q8    = FULL_TURN_Q8 / 2;
  localparam int QUARTER_TURN_Q8 = FULL_TURN_Q8 / 4;
  localparam int RED_STEPS       = $clog2((2 ** (ANGLE_W - 1)) / FULL_TURN_Q8 + 1);
  localparam int RED_CW          = $clog2(RED_STEPS);
  localparam int FOLD_W          = 19;
  localparam int MAG_W           = 15;

  // radians = mag * pi_q30 / half_turn, split as quotient plus remainder part
  localparam longint PI_Q30   = 64'd3373259426;
  localparam longint PI_QUO   = PI_Q30 / HALF_TURN_Q8;
  localparam longint PI_REM   = PI_Q30 % HALF_TURN_Q8;
  localparam int     DIV_SH   = 10;
  localparam int     DIV_ODD  = HALF_TURN_Q8 / (2 ** DIV_SH);
  localparam int     RECIP_SH = 24;
  localparam longint RECIP    = (64'd1 << RECIP_SH) / DIV_ODD;
  localparam int     N_W      = 19;
  localparam int     Q_W      = 14;
  localparam int     RAD_W    = 32;

  localparam longint GAIN_Q30 = 64'd652032874;

  typedef struct packed {
    logic                 start;
    logic                 flip;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [EW-1:0] cs;
    logic signed [EW-1:0] sn;
  } cordic_rsp_t;

  function automatic logic [30:0] atan_q30(input logic [ATAN_IW-1:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:    v = 31'h3243F6A8;
      5'd1:    v = 31'h1DAC6705;
      5'd2:    v = 31'h0FADBAFC;
      5'd3:    v = 31'h07F56EA6;
      5'd4:    v = 31'h03FEAB76;
      5'd5:    v = 31'h01FFD55B;
      5'd6:    v = 31'h00FFFAAA;
      5'd7:    v = 31'h007FFF55;
      5'd8:    v = 31'h003FFFEA;
      5'd9:    v = 31'h001FFFFD;
      5'd10:   v = 31'h000FFFFF;
      5'd11:   v = 31'h0007FFFF;
      5'd12:   v = 31'h0003FFFF;
      5'd13:   v = 31'h0001FFFF;
      5'd14:   v = 31'h0000FFFF;
      5'd15:   v = 31'h00007FFF;
      5'd16:   v = 31'h00003FFF;
      5'd17:   v = 31'h00001FFF;
      5'd18:   v = 31'h00000FFF;
      5'd19:   v = 31'h000007FF;
      5'd20:   v = 31'h000003FF;
      5'd21:   v = 31'h000001FF;
      5'd22:   v = 31'h000000FF;
      5'd23:   v = 31'h0000007F;
      5'd24:   v = 31'h0000003F;
      5'd25:   v = 31'h0000001F;
      5'd26:   v = 31'h0000000F;
      5'd27:   v = 31'h00000007;
      5'd28:   v = 31'h00000003;
      5'd29:   v = 31'h00000001;
      default: v = 31'h00000000;
    endcase
    return v;
  endfunction

  // round half up by sh bits, then clamp to the entry range
  function automatic logic signed [EW-1:0] round_sat(input logic signed [63:0] v,
                                                      input int unsigned sh);
    logic signed [63:0] r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (FRAC_BITS + 1)) - 64'sd1;
    lo = -(64'sd1 <<< (FRAC_BITS + 1));
    if (sh == 0) r = v;
    else         r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > hi)      r = hi;
    else if (r < lo) r = lo;
    return r[EW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/euler_channel_rotation_compose_core.sv
// top level: sequencer, angle reduction, matrix store and output register
//
// Builds one joint's 3x3 rotation matrix from a stream of channel words. A word
// with the first flag restarts the matrix from identity; x/y/z rotation kinds
// right-multiply it by the elementary rotation by the word's angle (degrees,
// signed Q15.8), all other kinds leave it as is. On a word with tlast the nine
// Q1.16 entries leave as one output word. One word is taken at a time: a
// rotation word occupies the block through the seven-step angle reduction,
// three products through the shared multiplier for the degree-to-radian
// scaling, one cordic step per cycle, and twelve products of the matrix
// update through that same multiplier; any other kind goes straight to the
// done state. A finished matrix waits in the output register while the next
// words are worked on.
`default_nettype none

module euler_channel_rotation_compose_core #(
  parameter int CORDIC_STEPS = ecrc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ecrc_pkg::IN_TDATA_W-1:0]     in_tdata,   // angle_deg
  input  wire logic [ecrc_pkg::IN_TUSER_W-1:0]     in_tuser,   // channel_kind, is_first
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ecrc_pkg::OUT_TDATA_W-1:0]         out_tdata   // m00..m22, row by row
);

  localparam int EW  = ecrc_pkg::EW;
  localparam int MW  = ecrc_pkg::MW;
  localparam int PW  = ecrc_pkg::PW;
  localparam int ZW  = ecrc_pkg::ZW;
  localparam int AW  = ecrc_pkg::FOLD_W;
  localparam int IW  = ecrc_pkg::ENT_IW;
  localparam int NW  = ecrc_pkg::N_W;
  localparam int QW  = ecrc_pkg::Q_W;
  localparam int ANW = ecrc_pkg::ANGLE_W;

  localparam logic signed [EW-1:0] ENT_ONE = EW'(1 << ecrc_pkg::FRAC_BITS);
  localparam logic signed [AW-1:0] FT = AW'(ecrc_pkg::FULL_TURN_Q8);
  localparam logic signed [AW-1:0] HT = AW'(ecrc_pkg::HALF_TURN_Q8);
  localparam logic signed [AW-1:0] QT = AW'(ecrc_pkg::QUARTER_TURN_Q8);

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_FOLD, ST_RAD0, ST_RAD1, ST_RAD2, ST_RAD3,
    ST_CORD, ST_MAT, ST_DONE
  } state_t;

  state_t                  state_r;
  logic                    last_r;
  logic                    sgn_r;
  logic [1:0]              col_p_r;
  logic [1:0]              col_q_r;
  logic [ANW-1:0]          rem_r;
  logic [ecrc_pkg::RED_CW-1:0] red_cnt_r;
  logic [ecrc_pkg::MAG_W-1:0]  mag_r;
  logic                    neg_r;
  logic                    flip_r;
  logic [NW-1:0]           n_r;
  logic [QW-1:0]           q_r;
  logic signed [EW-1:0]    mat_r [ecrc_pkg::NUM_ENT];
  logic [1:0]              row_r;
  logic [1:0]              term_r;
  logic                    iss_act_r;
  logic                    tg_vld_r;
  logic [1:0]              tg_row_r;
  logic [1:0]              tg_term_r;
  logic signed [PW-1:0]    acc_r;
  logic signed [EW-1:0]    newp_r;
  logic                    out_vld_r;
  logic [ecrc_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic signed [MW-1:0]    mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  ecrc_pkg::cordic_req_t   creq;
  ecrc_pkg::cordic_rsp_t   crsp;

  logic                    in_acc;
  logic signed [ANW-1:0]   angle_in;
  logic [ANW-1:0]          red_sub;
  logic [ANW-1:0]          rem_nxt;
  logic signed [AW-1:0]    a0;
  logic signed [AW-1:0]    a1;
  logic signed [AW-1:0]    a2;
  logic signed [AW-1:0]    amag;
  logic                    flip_nxt;
  logic [NW-1:0]           n_cur;
  logic [QW-1:0]           q_est;
  logic [NW:0]             q45;
  logic [NW:0]             n_res;
  logic [QW-1:0]           q_nxt;
  logic [ecrc_pkg::RAD_W-1:0] rad;
  logic signed [ZW-1:0]    z_nxt;
  logic [1:0]              rd_col;
  logic [IW-1:0]           rd_idx;
  logic [IW-1:0]           wp_idx;
  logic [IW-1:0]           wq_idx;
  logic signed [PW:0]      sum_p;
  logic signed [PW:0]      dif_q;
  logic                    out_load;
  logic [ecrc_pkg::OUT_TDATA_W-1:0] out_pack;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign angle_in  = signed'(in_tdata[ANW-1:0]);

  // angle reduction, one compare and subtract per cycle
  always_comb begin
    red_sub = ANW'(ecrc_pkg::FULL_TURN_Q8) << red_cnt_r;
    rem_nxt = (rem_r >= red_sub) ? rem_r - red_sub : rem_r;
  end

  // map into [-180, 180) and fold into [-90, 90]
  always_comb begin
    a0 = (sgn_r && rem_r != '0) ? FT - AW'(rem_r) : AW'(rem_r);
    a1 = (a0 >= HT) ? a0 - FT : a0;
    flip_nxt = 1'b0;
    priority if (a1 > QT) begin
      a2 = a1 - HT;
      flip_nxt = 1'b1;
    end else if (a1 < -QT) begin
      a2 = a1 + HT;
      flip_nxt = 1'b1;
    end else begin
      a2 = a1;
    end
    amag = a2[AW-1] ? -a2 : a2;
  end

  // radian scaling
  always_comb begin
    n_cur = mul_p[NW+ecrc_pkg::DIV_SH-1:ecrc_pkg::DIV_SH];
    q_est = mul_p[ecrc_pkg::RECIP_SH+QW-1:ecrc_pkg::RECIP_SH];
    q45   = (NW+1)'(q_est) * (NW+1)'(ecrc_pkg::DIV_ODD);
    n_res = {1'b0, n_r} - q45;
    q_nxt = (n_res >= (NW+1)'(ecrc_pkg::DIV_ODD)) ? q_est + QW'(1) : q_est;
    rad   = mul_p[ecrc_pkg::RAD_W-1:0] + ecrc_pkg::RAD_W'(q_r);
    z_nxt = neg_r ? -ZW'(rad) : ZW'(rad);
  end

  // matrix addressing
  always_comb begin
    rd_col = (term_r == 2'd0 || term_r == 2'd3) ? col_p_r : col_q_r;
    rd_idx = IW'(row_r) * IW'(3) + IW'(rd_col);
    wp_idx = IW'(tg_row_r) * IW'(3) + IW'(col_p_r);
    wq_idx = IW'(tg_row_r) * IW'(3) + IW'(col_q_r);
    sum_p  = (PW+1)'(acc_r) + (PW+1)'(mul_p);
    dif_q  = (PW+1)'(acc_r) - (PW+1)'(mul_p);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_RAD0: begin
        mul_a = MW'(mag_r);
        mul_b = MW'(ecrc_pkg::PI_REM);
      end
      ST_RAD1: begin
        mul_a = MW'(n_cur);
        mul_b = MW'(ecrc_pkg::RECIP);
      end
      ST_RAD2: begin
        mul_a = MW'(mag_r);
        mul_b = MW'(ecrc_pkg::PI_QUO);
      end
      ST_MAT: begin
        mul_a = MW'(mat_r[rd_idx]);
        mul_b = term_r[0] ? MW'(crsp.sn) : MW'(crsp.cs);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    creq.start = (state_r == ST_RAD3);
    creq.flip  = flip_r;
    creq.z     = z_nxt;
  end

  always_comb begin
    out_pack = '0;
    for (int k = 0; k < ecrc_pkg::NUM_ENT; k++) begin
      out_pack[k*EW +: EW] = mat_r[k];
    end
  end

  assign out_load = (state_r == ST_DONE) && last_r && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      iss_act_r <= 1'b0;
      tg_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k < ecrc_pkg::NUM_ENT; k++) begin
        mat_r[k] <= (k % 4 == 0) ? ENT_ONE : '0;
      end
    end else begin
      tg_vld_r <= 1'b0;
      if (out_load) begin
        out_vld_r  <= 1'b1;
        out_data_r <= out_pack;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            rem_r     <= angle_in[ANW-1] ? ANW'(-angle_in) : ANW'(angle_in);
            sgn_r     <= angle_in[ANW-1];
            red_cnt_r <= ecrc_pkg::RED_CW'(ecrc_pkg::RED_STEPS - 1);
            last_r    <= in_tlast;
            if (in_tuser[ecrc_pkg::KIND_W]) begin
              for (int k = 0; k < ecrc_pkg::NUM_ENT; k++) begin
                mat_r[k] <= (k % 4 == 0) ? ENT_ONE : '0;
              end
            end
            unique case (in_tuser[ecrc_pkg::KIND_W-1:0])
              ecrc_pkg::KIND_ROT_X: begin
                col_p_r <= 2'd1;
                col_q_r <= 2'd2;
                state_r <= ST_REDUCE;
              end
              ecrc_pkg::KIND_ROT_Y: begin
                col_p_r <= 2'd2;
                col_q_r <= 2'd0;
                state_r <= ST_REDUCE;
              end
              ecrc_pkg::KIND_ROT_Z: begin
                col_p_r <= 2'd0;
                col_q_r <= 2'd1;
                state_r <= ST_REDUCE;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_REDUCE: begin
          rem_r <= rem_nxt;
          if (red_cnt_r == '0) state_r <= ST_FOLD;
          else                 red_cnt_r <= red_cnt_r - ecrc_pkg::RED_CW'(1);
        end
        ST_FOLD: begin
          mag_r   <= ecrc_pkg::MAG_W'(amag);
          neg_r   <= a2[AW-1];
          flip_r  <= flip_nxt;
          state_r <= ST_RAD0;
        end
        ST_RAD0: state_r <= ST_RAD1;
        ST_RAD1: begin
          n_r     <= n_cur;
          state_r <= ST_RAD2;
        end
        ST_RAD2: begin
          q_r     <= q_nxt;
          state_r <= ST_RAD3;
        end
        ST_RAD3: state_r <= ST_CORD;
        ST_CORD: begin
          if (crsp.done) begin
            row_r     <= 2'd0;
            term_r    <= 2'd0;
            iss_act_r <= 1'b1;
            state_r   <= ST_MAT;
          end
        end
        ST_MAT: begin
          if (iss_act_r) begin
            tg_vld_r  <= 1'b1;
            tg_row_r  <= row_r;
            tg_term_r <= term_r;
            term_r    <= term_r + 2'd1;
            if (term_r == 2'd3) row_r <= row_r + 2'd1;
            if (term_r == 2'd3 && row_r == 2'd2) iss_act_r <= 1'b0;
          end
          if (tg_vld_r) begin
            unique case (tg_term_r)
              2'd0, 2'd2: acc_r <= mul_p;
              2'd1: newp_r <= ecrc_pkg::round_sat(64'(sum_p), ecrc_pkg::FRAC_BITS);
              2'd3: begin
                mat_r[wp_idx] <= newp_r;
                mat_r[wq_idx] <= ecrc_pkg::round_sat(64'(dif_q), ecrc_pkg::FRAC_BITS);
                if (tg_row_r == 2'd2) state_r <= ST_DONE;
              end
              default: acc_r <= mul_p;
            endcase
          end
        end
        ST_DONE: begin
          if (!last_r || out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  ecrc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  ecrc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    crsp.done |-> state_r == ST_CORD)
    else $error("cordic result outside its wait state");

  a_tag_in_mat: assert property (@(posedge clk) disable iff (!rst_n)
    tg_vld_r |-> state_r == ST_MAT)
    else $error("matrix product tag outside matrix update");

  a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FOLD |-> rem_r < ANW'(ecrc_pkg::FULL_TURN_Q8))
    else $error("angle reduction left a remainder of a full turn or more");

  a_folded_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RAD0 |-> mag_r <= ecrc_pkg::MAG_W'(ecrc_pkg::QUARTER_TURN_Q8))
    else $error("folded angle beyond a quarter turn");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_vld_r || out_tready)
    else $error("output register overwritten while full");

endmodule

`default_nettype wire

### rtl/core/ecrc_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module ecrc_mul (
  input  wire logic                              clk,
  input  wire logic signed [ecrc_pkg::MW-1:0]    a,
  input  wire logic signed [ecrc_pkg::MW-1:0]    b,
  output logic signed      [ecrc_pkg::PW-1:0]    p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

### rtl/core/ecrc_cordic.sv
// iterative rotation-mode cordic giving rounded cosine and sine
`default_nettype none

module ecrc_cordic #(
  parameter int CORDIC_STEPS = ecrc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ecrc_pkg::cordic_req_t req,
  output ecrc_pkg::cordic_rsp_t      rsp
);

  localparam int SCW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int RSH = ecrc_pkg::CORDIC_FRAC - ecrc_pkg::FRAC_BITS;

  logic                           run_r;
  logic                           fin_r;
  logic                           done_r;
  logic [SCW-1:0]                 step_r;
  logic                           flip_r;
  logic signed [ecrc_pkg::ZW-1:0] x_r;
  logic signed [ecrc_pkg::ZW-1:0] y_r;
  logic signed [ecrc_pkg::ZW-1:0] z_r;
  logic signed [ecrc_pkg::EW-1:0] cs_r;
  logic signed [ecrc_pkg::EW-1:0] sn_r;

  logic signed [ecrc_pkg::ZW-1:0] dx;
  logic signed [ecrc_pkg::ZW-1:0] dy;
  logic signed [ecrc_pkg::ZW-1:0] at_v;
  logic signed [ecrc_pkg::ZW-1:0] x_fin;
  logic signed [ecrc_pkg::ZW-1:0] y_fin;

  assign dx    = y_r >>> step_r;
  assign dy    = x_r >>> step_r;
  assign at_v  = ecrc_pkg::ZW'(ecrc_pkg::atan_q30(ecrc_pkg::ATAN_IW'(step_r)));
  assign x_fin = flip_r ? -x_r : x_r;
  assign y_fin = flip_r ? -y_r : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        fin_r  <= 1'b0;
        step_r <= '0;
        flip_r <= req.flip;
        x_r    <= ecrc_pkg::ZW'(ecrc_pkg::GAIN_Q30);
        y_r    <= '0;
        z_r    <= req.z;
      end else if (run_r) begin
        if (!z_r[ecrc_pkg::ZW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at_v;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at_v;
        end
        step_r <= step_r + SCW'(1);
        if (step_r == SCW'(CORDIC_STEPS - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        cs_r   <= ecrc_pkg::round_sat(64'(x_fin), RSH);
        sn_r   <= ecrc_pkg::round_sat(64'(y_fin), RSH);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.cs   = cs_r;
  assign rsp.sn   = sn_r;

endmodule

`default_nettype wire
